@@ src/lcmn_pkg.sv @@
// Shared types, codes and field widths of the counting mutex node.
`default_nettype none

package lcmn_pkg;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam int CLK_W  = 31;
  localparam int NODE_W = 4;
  localparam int CNT_W  = 5;
  localparam int QID_W  = 2;
  localparam int TAG_W  = 2;
  localparam int OQ_W   = 3;
  localparam int MASK_W = 16;

  typedef enum logic [2:0] {
    KIND_RECV_REQ = 3'd0,
    KIND_RECV_OK  = 3'd1,
    KIND_RECV_END = 3'd2,
    KIND_ACQUIRE  = 3'd3,
    KIND_RELEASE  = 3'd4,
    KIND_JOIN     = 3'd5
  } kind_e;

  localparam logic [TAG_W-1:0] TAG_REQ = 2'd0;
  localparam logic [TAG_W-1:0] TAG_OK  = 2'd1;
  localparam logic [TAG_W-1:0] TAG_END = 2'd2;

  localparam logic [OQ_W-1:0]  QUEUE_NONE = 3'b111;
  localparam logic [CLK_W-1:0] CLOCK_MAX  = 31'h7FFF_FFFF;
  localparam logic [CNT_W-1:0] CNT_MAX    = 5'd31;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_NODES = 1'b1;

  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_now;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ src/lamport_counting_mutex_node.sv @@
// An accepted item is captured, executed into the sequencing registers, and each of its
// results (at least one) is registered in the output register. Broadcasts and deferred
// releases emit one item per cycle while the output is not stalled, set by the result
// sequencer walking the destination mask one rank at a time; the final result frees input.
// Reset: asynchronous, active low; clears clock, flags, masks and counts; node count set to 1.
`default_nettype none

module lamport_counting_mutex_node import lcmn_pkg::*; #(
  parameter int MAX_NODES = 16,
  parameter int QUEUES    = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // src_node[3:0], msg_time[34:4], queue_sel[36:35], capacity[41:37], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // req_type[2:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // send_valid[0], dest_node[4:1], out_tag[6:5], out_stamp[37:7], out_queue[40:38], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // granted[0], join_done[1]
  output logic [OUT_USER_W-1:0] m_axis_tuser_o,
  output logic                  m_axis_tlast_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lcmn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lcmn_datapath #(
    .MAX_NODES (MAX_NODES),
    .QUEUES    (QUEUES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

`default_nettype wire

@@ src/lcmn_ctrl.sv @@
// Controller state machine: accept, execute and result sequencing.
`default_nettype none

module lcmn_ctrl import lcmn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       emit_last;

  // the final result of an item frees the input side in the same cycle
  assign emit_last  = (state_q == S_EMIT) && status_i.out_free && status_i.last_now;
  assign s_tready_o = (state_q == S_IDLE) || emit_last;

  always_comb begin
    cmd_o.load = s_tvalid_i && s_tready_o;
    cmd_o.exec = (state_q == S_EXEC);
    cmd_o.emit = (state_q == S_EMIT) && status_i.out_free;
    state_d    = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (emit_last) state_d = s_tvalid_i ? S_EXEC : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ src/lcmn_datapath.sv @@
// Datapath: clock, queue state, deferred masks and the result register.
`default_nettype none

module lcmn_datapath import lcmn_pkg::*; #(
  parameter int MAX_NODES = 16,
  parameter int QUEUES    = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic [IN_USER_W-1:0]  s_tuser_i,
  input  logic                  m_tready_i,
  output logic                  m_tvalid_o,
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  output logic [OUT_USER_W-1:0] m_tuser_o,
  output logic                  m_tlast_o,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o
);

  localparam int QIW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int GMAX = (MAX_NODES < 16) ? MAX_NODES : 16;
  localparam logic [CNT_W-1:0] GMAX_C = CNT_W'(GMAX);

  // configuration
  logic [NODE_W-1:0] node_id_q;
  logic [CNT_W-1:0]  num_nodes_q;

  // captured item
  kind_e             kind_q;
  logic [NODE_W-1:0] src_q;
  logic [CLK_W-1:0]  mt_q;
  logic [QID_W-1:0]  qid_q;
  logic [CNT_W-1:0]  cap_q;

  // protocol state
  logic [CLK_W-1:0]  clock_q, clock_d;
  logic [QUEUES-1:0] requesting_q, requesting_d;
  logic [QUEUES-1:0] holding_q, holding_d;
  logic [MASK_W-1:0] deferred_q [QUEUES];
  logic [MASK_W-1:0] deferred_d [QUEUES];
  logic [CNT_W-1:0]  okcnt_q [QUEUES];
  logic [CNT_W-1:0]  okcnt_d [QUEUES];
  logic [CLK_W-1:0]  pstamp_q, pstamp_d;
  logic [QIW-1:0]    pq_q, pq_d;
  logic [CNT_W-1:0]  need_q, need_d;
  logic [CNT_W-1:0]  exit_q, exit_d;

  // result sequencing
  logic [MASK_W-1:0] rem_q, rem_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [OQ_W-1:0]   oq_q, oq_d;
  logic              grant_q, grant_d;
  logic              joined_q, joined_d;

  // output register
  logic                  m_tvalid_q;
  logic [OUT_DATA_W-1:0] m_tdata_q;
  logic [OUT_USER_W-1:0] m_tuser_q;
  logic                  m_tlast_q;

  logic              qok;
  logic [QIW-1:0]    qidx;
  logic [CNT_W-1:0]  g;
  logic [MASK_W:0]   below_g;
  logic [MASK_W-1:0] bmask;
  logic [CLK_W-1:0]  m_rx, clk_rx1, clk_rx2, clk_loc;
  logic              req, hold, wins;
  logic [CNT_W-1:0]  cnt_inc, exit_inc, need_new;
  logic [MASK_W-1:0] rem_next;
  logic              last_now;
  logic [NODE_W-1:0] dest;
  logic [OUT_DATA_W-1:0] res_data;
  logic [OUT_USER_W-1:0] res_user;

  assign qok  = (32'(qid_q) < QUEUES);
  assign qidx = QIW'(qid_q);

  assign g       = (num_nodes_q > GMAX_C) ? GMAX_C : num_nodes_q;
  assign below_g = ((MASK_W+1)'(1) << g) - (MASK_W+1)'(1);
  assign bmask   = below_g[MASK_W-1:0] & ~(MASK_W'(1) << node_id_q);

  // saturating Lamport ticks; a granted REQ ticks twice, folded into one add
  assign m_rx    = (clock_q > mt_q) ? clock_q : mt_q;
  assign clk_rx1 = (m_rx == CLOCK_MAX) ? CLOCK_MAX : m_rx + 31'd1;
  assign clk_rx2 = (m_rx >= CLOCK_MAX - 31'd1) ? CLOCK_MAX : m_rx + 31'd2;
  assign clk_loc = (clock_q == CLOCK_MAX) ? CLOCK_MAX : clock_q + 31'd1;

  assign req  = qok && requesting_q[qidx];
  assign hold = qok && holding_q[qidx];
  assign wins = (mt_q == pstamp_q) ? (src_q < node_id_q) : (mt_q < pstamp_q);

  assign cnt_inc  = (okcnt_q[qidx] == CNT_MAX) ? okcnt_q[qidx] : okcnt_q[qidx] + 5'd1;
  assign exit_inc = (exit_q == CNT_MAX) ? exit_q : exit_q + 5'd1;
  assign need_new = (g > cap_q) ? g - cap_q : '0;

  assign rem_next = rem_q & (rem_q - MASK_W'(1));
  assign last_now = (rem_next == '0);

  always_comb begin
    dest = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (rem_q[i]) dest = NODE_W'(i);
    end
  end

  always_comb begin
    if (rem_q == '0) begin
      res_data = '0;
    end else begin
      res_data = {{(OUT_DATA_W - 41){1'b0}}, oq_q, clock_q, tag_q, dest, 1'b1};
    end
    res_user = last_now ? {joined_q, grant_q} : '0;
  end

  assign status_o.last_now = last_now;
  assign status_o.out_free = !m_tvalid_q || m_tready_i;

  always_comb begin
    clock_d      = clock_q;
    requesting_d = requesting_q;
    holding_d    = holding_q;
    deferred_d   = deferred_q;
    okcnt_d      = okcnt_q;
    pstamp_d     = pstamp_q;
    pq_d         = pq_q;
    need_d       = need_q;
    exit_d       = exit_q;
    rem_d        = rem_q;
    tag_d        = tag_q;
    oq_d         = oq_q;
    grant_d      = grant_q;
    joined_d     = joined_q;
    if (cmd_i.exec) begin
      rem_d    = '0;
      tag_d    = TAG_REQ;
      oq_d     = {1'b0, qid_q};
      grant_d  = 1'b0;
      joined_d = 1'b0;
      case (kind_q)
        KIND_RECV_REQ: begin
          clock_d = clk_rx1;
          if ((!req && !hold) || (req && wins)) begin
            clock_d = clk_rx2;
            rem_d   = MASK_W'(1) << src_q;
            tag_d   = TAG_OK;
          end else if (32'(src_q) < MAX_NODES) begin
            deferred_d[qidx] = deferred_q[qidx] | (MASK_W'(1) << src_q);
          end
        end
        KIND_RECV_OK: begin
          clock_d = clk_rx1;
          if (qok) begin
            okcnt_d[qidx] = cnt_inc;
            // only the pending queue can be requested, so check it alone
            if (requesting_q[qidx] && (pq_q == qidx) && (cnt_inc >= need_q)) begin
              requesting_d[qidx] = 1'b0;
              holding_d[qidx]    = 1'b1;
              grant_d            = 1'b1;
            end
          end
        end
        KIND_RECV_END: begin
          clock_d = clk_rx1;
          if (exit_inc >= g) begin
            joined_d = 1'b1;
            exit_d   = '0;
          end else begin
            exit_d = exit_inc;
          end
        end
        KIND_ACQUIRE: begin
          if (requesting_q == '0) begin
            clock_d  = clk_loc;
            pstamp_d = clk_loc;
            rem_d    = bmask;
            tag_d    = TAG_REQ;
            if (qok) begin
              pq_d               = qidx;
              need_d             = need_new;
              requesting_d[qidx] = 1'b1;
              okcnt_d[qidx]      = '0;
              if (need_new == '0) begin
                requesting_d[qidx] = 1'b0;
                holding_d[qidx]    = 1'b1;
                grant_d            = 1'b1;
              end
            end
          end
        end
        KIND_RELEASE: begin
          clock_d = clk_loc;
          if (qok) begin
            rem_d            = deferred_q[qidx];
            tag_d            = TAG_OK;
            deferred_d[qidx] = '0;
            holding_d[qidx]  = 1'b0;
          end
        end
        KIND_JOIN: begin
          clock_d = clk_loc;
          rem_d   = bmask;
          tag_d   = TAG_END;
          oq_d    = QUEUE_NONE;
          if (exit_inc >= g) begin
            joined_d = 1'b1;
            exit_d   = '0;
          end else begin
            exit_d = exit_inc;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd_i.emit) begin
      rem_d = rem_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q    <= '0;
      num_nodes_q  <= 5'd1;
      clock_q      <= '0;
      requesting_q <= '0;
      holding_q    <= '0;
      for (int i = 0; i < QUEUES; i++) begin
        deferred_q[i] <= '0;
        okcnt_q[i]    <= '0;
      end
      pstamp_q     <= '0;
      pq_q         <= '0;
      need_q       <= '0;
      exit_q       <= '0;
      rem_q        <= '0;
      tag_q        <= TAG_REQ;
      oq_q         <= '0;
      grant_q      <= 1'b0;
      joined_q     <= 1'b0;
      m_tvalid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NODE_ID:   node_id_q   <= cfg_data_i[NODE_W-1:0];
          CFG_NUM_NODES: num_nodes_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      clock_q      <= clock_d;
      requesting_q <= requesting_d;
      holding_q    <= holding_d;
      deferred_q   <= deferred_d;
      okcnt_q      <= okcnt_d;
      pstamp_q     <= pstamp_d;
      pq_q         <= pq_d;
      need_q       <= need_d;
      exit_q       <= exit_d;
      rem_q        <= rem_d;
      tag_q        <= tag_d;
      oq_q         <= oq_d;
      grant_q      <= grant_d;
      joined_q     <= joined_d;
      if (cmd_i.emit) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // payload registers: captured item and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_e'(s_tuser_i[2:0]);
      src_q  <= s_tdata_i[3:0];
      mt_q   <= s_tdata_i[34:4];
      qid_q  <= s_tdata_i[36:35];
      cap_q  <= s_tdata_i[41:37];
    end
    if (cmd_i.emit) begin
      m_tdata_q <= res_data;
      m_tuser_q <= res_user;
      m_tlast_q <= last_now;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;
  assign m_tlast_o  = m_tlast_q;

endmodule

`default_nettype wire

@@ src/lcmn_checker.sv @@
// Port-level assertions for the counting mutex node, bound to the top level.
`default_nettype none

module lcmn_checker import lcmn_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [OUT_USER_W-1:0] m_axis_tuser_o,
  input logic                  m_axis_tlast_o
);

  // a stalled result holds its valid, data and last
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // an item without a message is the only result of its input, with empty data
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tlast_o && (m_axis_tdata_o == '0))
    else $error("empty result not sole and clean");

  // grant and join marks ride only on the final result
  a_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != '0) |-> m_axis_tlast_o)
    else $error("mark before final result");

  // END messages carry no queue, others carry a real one
  a_endq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |->
      ((m_axis_tdata_o[6:5] == TAG_END) == (m_axis_tdata_o[40:38] == QUEUE_NONE)))
    else $error("queue field does not match message kind");

endmodule

bind lamport_counting_mutex_node lcmn_checker u_lcmn_checker (.*);

`default_nettype wire
